### hw/rtl/qrs_pkg.sv
// shared widths, root kind codes and the front-to-back item type of the quadratic solver
package qrs_pkg;

    localparam int COEF_W          = 24;
    localparam int DISC_W          = 50;
    localparam int ROOT_W          = 32;
    localparam int KIND_W          = 3;
    localparam int RAD_SHIFT       = 14;
    localparam int RAD_W           = DISC_W + RAD_SHIFT;
    localparam int SQRT_W          = RAD_W / 2;
    localparam int SQ_REM_W        = SQRT_W + 4;
    localparam int NUM_W           = 44;
    localparam int DEN_W           = COEF_W + 1;
    localparam int QRS_QUEUE_DEPTH = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_DEGEN    = 3'd0,
        KIND_LINEAR   = 3'd1,
        KIND_TWO_REAL = 3'd2,
        KIND_DOUBLE   = 3'd3,
        KIND_COMPLEX  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [DISC_W-1:0]  disc;
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
        logic signed [COEF_W-1:0]  c;
    } t_front_item;

endpackage

### hw/rtl/qrs_ifs.sv
// coefficient and result channel interfaces of the quadratic solver
interface qrs_in_if import qrs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if import qrs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        root_kind;
    logic signed [DISC_W-1:0] discriminant;
    logic signed [ROOT_W-1:0] first_root;
    logic signed [ROOT_W-1:0] second_root;
    logic signed [ROOT_W-1:0] imag_part;
    logic                     saturated;

    modport source (output valid, output root_kind, output discriminant, output first_root,
                    output second_root, output imag_part, output saturated, input ready);
    modport sink   (input valid, input root_kind, input discriminant, input first_root,
                    input second_root, input imag_part, input saturated, output ready);
endinterface

### hw/rtl/qrs_front.sv
// front end: products, discriminant and root kind classification
module qrs_front import qrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qrs_in_if.sink      i_in,
    output t_front_item o_item,
    output logic        o_item_valid,
    input  logic        i_item_ready
);

    logic                       en;
    logic                       r_v1;
    logic                       r_v2;
    logic signed [2*COEF_W-1:0] r_bb;
    logic signed [2*COEF_W-1:0] r_ac;
    logic signed [COEF_W-1:0]   r_a;
    logic signed [COEF_W-1:0]   r_b;
    logic signed [COEF_W-1:0]   r_c;
    logic signed [DISC_W-1:0]   n_disc;
    t_front_item                n_item;
    t_front_item                r_item;

    assign en         = !r_v2 || i_item_ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bb   <= (2*COEF_W)'(i_in.coef_b) * (2*COEF_W)'(i_in.coef_b);
            r_ac   <= (2*COEF_W)'(i_in.coef_a) * (2*COEF_W)'(i_in.coef_c);
            r_a    <= i_in.coef_a;
            r_b    <= i_in.coef_b;
            r_c    <= i_in.coef_c;
            r_item <= n_item;
        end
    end

    assign n_disc = DISC_W'(r_bb) - (DISC_W'(r_ac) <<< 2);

    always_comb begin
        n_item.a = r_a;
        n_item.b = r_b;
        n_item.c = r_c;
        if (r_a == '0) begin
            n_item.disc = '0;
            n_item.kind = (r_b == '0) ? KIND_DEGEN : KIND_LINEAR;
        end else begin
            n_item.disc = n_disc;
            if (n_disc == '0) begin
                n_item.kind = KIND_DOUBLE;
            end else if (n_disc[DISC_W-1]) begin
                n_item.kind = KIND_COMPLEX;
            end else begin
                n_item.kind = KIND_TWO_REAL;
            end
        end
    end

    assign o_item       = r_item;
    assign o_item_valid = r_v2;

endmodule

### hw/rtl/qrs_fifo.sv
// small register queue between the front end and the root pipeline
module qrs_fifo import qrs_pkg::*; #(
    parameter int DEPTH = QRS_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_front_item i_data,
    input  logic        i_valid,
    output logic        o_ready,
    output t_front_item o_data,
    output logic        o_valid,
    input  logic        i_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_front_item       r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              push;
    logic              pop;

    assign o_ready = r_cnt != CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### hw/rtl/qrs_back.sv
// back end: bit-serial pipelined square root, rounded dividers and saturation
module qrs_back import qrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_front_item i_item,
    input  logic        i_item_valid,
    output logic        o_item_ready,
    qrs_out_if.source   o_out
);

    localparam int SQ_STAGES = SQRT_W;
    localparam int DV_STAGES = NUM_W;
    localparam int NLANE     = 3;
    localparam int LANE_X1   = 0;
    localparam int LANE_X2   = 1;
    localparam int LANE_IM   = 2;
    localparam logic [NUM_W-1:0] MAG_NEG = NUM_W'(1) << (ROOT_W - 1);
    localparam logic [NUM_W-1:0] MAG_POS = MAG_NEG - 1'b1;

    typedef struct packed {
        t_kind                    kind;
        logic signed [DISC_W-1:0] disc;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic [RAD_W-1:0]         rad;
        logic [SQ_REM_W-1:0]      rem;
        logic [SQRT_W-1:0]        root;
    } t_sq_stage;

    typedef struct packed {
        logic [NUM_W-1:0] n;
        logic [DEN_W-1:0] d;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] q;
        logic             neg;
    } t_lane;

    typedef struct packed {
        t_kind                    kind;
        logic signed [DISC_W-1:0] disc;
        t_lane [NLANE-1:0]        lane;
    } t_dv_stage;

    typedef struct packed {
        logic                     sat;
        logic signed [ROOT_W-1:0] v;
    } t_rnd;

    function automatic t_sq_stage sqrt_step(input t_sq_stage s);
        t_sq_stage           o;
        logic [SQ_REM_W-1:0] rw;
        logic [SQ_REM_W-1:0] cand;
        o    = s;
        rw   = {s.rem[SQ_REM_W-3:0], s.rad[RAD_W-1 -: 2]};
        cand = {{(SQ_REM_W-SQRT_W-2){1'b0}}, s.root, 2'b01};
        o.rad = s.rad << 2;
        if (rw >= cand) begin
            o.rem  = rw - cand;
            o.root = {s.root[SQRT_W-2:0], 1'b1};
        end else begin
            o.rem  = rw;
            o.root = {s.root[SQRT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // rounded division set up as floor((2|n| + |d|) / (2|d|))
    function automatic t_lane lane_prep(input logic signed [NUM_W-1:0] num,
                                        input logic signed [COEF_W-1:0] den);
        t_lane             l;
        logic [NUM_W-1:0]  un;
        logic [COEF_W-1:0] ud;
        un    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        ud    = den[COEF_W-1] ? COEF_W'(-den) : COEF_W'(den);
        l.n   = (un << 1) + NUM_W'(ud);
        l.d   = {ud, 1'b0};
        l.rem = '0;
        l.q   = '0;
        l.neg = num[NUM_W-1] ^ den[COEF_W-1];
        return l;
    endfunction

    function automatic t_lane div_step(input t_lane l);
        t_lane          o;
        logic [DEN_W:0] rw;
        logic           ge;
        o   = l;
        rw  = {l.rem, l.n[NUM_W-1]};
        ge  = rw >= {1'b0, l.d};
        o.rem = ge ? DEN_W'(rw - {1'b0, l.d}) : DEN_W'(rw);
        o.q   = {l.q[NUM_W-2:0], ge};
        o.n   = l.n << 1;
        return o;
    endfunction

    function automatic t_rnd sat_round(input t_lane l);
        t_rnd r;
        r.sat = 1'b0;
        if (l.neg) begin
            if (l.q > MAG_NEG) begin
                r.sat = 1'b1;
                r.v   = {1'b1, {(ROOT_W-1){1'b0}}};
            end else begin
                r.v = ROOT_W'(NUM_W'(0) - l.q);
            end
        end else begin
            if (l.q > MAG_POS) begin
                r.sat = 1'b1;
                r.v   = {1'b0, {(ROOT_W-1){1'b1}}};
            end else begin
                r.v = ROOT_W'(l.q);
            end
        end
        return r;
    endfunction

    logic                     en;
    t_sq_stage                n_sq   [SQ_STAGES+1];
    t_sq_stage                r_sq   [SQ_STAGES+1];
    logic                     r_sq_v [SQ_STAGES+1];
    t_dv_stage                n_dv   [DV_STAGES+1];
    t_dv_stage                r_dv   [DV_STAGES+1];
    logic                     r_dv_v [DV_STAGES+1];
    logic [DISC_W-1:0]        mag;
    logic signed [NUM_W-1:0]  sx;
    logic signed [NUM_W-1:0]  nb;
    logic signed [NUM_W-1:0]  nc;
    logic signed [NUM_W-1:0]  nb7;
    logic signed [NUM_W-1:0]  num1;
    logic signed [COEF_W-1:0] den1;
    t_rnd                     rnd1;
    t_rnd                     rnd2;
    t_rnd                     rnd3;
    logic                     r_out_valid;
    t_kind                    r_kind;
    t_kind                    n_kind;
    logic signed [DISC_W-1:0] r_disc;
    logic signed [DISC_W-1:0] n_disc;
    logic signed [ROOT_W-1:0] r_r1;
    logic signed [ROOT_W-1:0] n_r1;
    logic signed [ROOT_W-1:0] r_r2;
    logic signed [ROOT_W-1:0] n_r2;
    logic signed [ROOT_W-1:0] r_im;
    logic signed [ROOT_W-1:0] n_im;
    logic                     r_sat;
    logic                     n_sat;

    assign en           = !r_out_valid || o_out.ready;
    assign o_item_ready = en;

    // square root stage zero: radicand |D| * 2^14
    assign mag = i_item.disc[DISC_W-1] ? DISC_W'(-i_item.disc) : DISC_W'(i_item.disc);

    always_comb begin
        n_sq[0].kind = i_item.kind;
        n_sq[0].disc = i_item.disc;
        n_sq[0].a    = i_item.a;
        n_sq[0].b    = i_item.b;
        n_sq[0].c    = i_item.c;
        n_sq[0].rad  = {mag, {RAD_SHIFT{1'b0}}};
        n_sq[0].rem  = '0;
        n_sq[0].root = '0;
    end

    for (genvar k = 0; k <= SQ_STAGES; k++) begin : g_sq
        if (k > 0) begin : g_step
            assign n_sq[k] = sqrt_step(r_sq[k-1]);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (en) begin
                r_sq_v[k] <= (k == 0) ? i_item_valid : r_sq_v[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k] <= n_sq[k];
            end
        end
    end

    // numerators of the three dividers
    assign sx  = $signed({{(NUM_W-SQRT_W){1'b0}}, r_sq[SQ_STAGES].root});
    assign nb  = -NUM_W'(r_sq[SQ_STAGES].b);
    assign nc  = -NUM_W'(r_sq[SQ_STAGES].c);
    assign nb7 = nb <<< 7;

    always_comb begin
        case (r_sq[SQ_STAGES].kind)
            KIND_TWO_REAL: num1 = (nb7 + sx) <<< 8;
            KIND_LINEAR:   num1 = nc <<< 16;
            default:       num1 = nb <<< 15;
        endcase
        den1 = (r_sq[SQ_STAGES].kind == KIND_LINEAR) ? r_sq[SQ_STAGES].b : r_sq[SQ_STAGES].a;
        n_dv[0].kind          = r_sq[SQ_STAGES].kind;
        n_dv[0].disc          = r_sq[SQ_STAGES].disc;
        n_dv[0].lane[LANE_X1] = lane_prep(num1, den1);
        n_dv[0].lane[LANE_X2] = lane_prep((nb7 - sx) <<< 8, r_sq[SQ_STAGES].a);
        n_dv[0].lane[LANE_IM] = lane_prep(sx <<< 8, r_sq[SQ_STAGES].a);
    end

    for (genvar k = 0; k <= DV_STAGES; k++) begin : g_dv
        if (k > 0) begin : g_step
            assign n_dv[k].kind = r_dv[k-1].kind;
            assign n_dv[k].disc = r_dv[k-1].disc;
            for (genvar j = 0; j < NLANE; j++) begin : g_lane
                assign n_dv[k].lane[j] = div_step(r_dv[k-1].lane[j]);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (en) begin
                r_dv_v[k] <= (k == 0) ? r_sq_v[SQ_STAGES] : r_dv_v[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // saturation and per-kind result selection
    assign rnd1 = sat_round(r_dv[DV_STAGES].lane[LANE_X1]);
    assign rnd2 = sat_round(r_dv[DV_STAGES].lane[LANE_X2]);
    assign rnd3 = sat_round(r_dv[DV_STAGES].lane[LANE_IM]);

    always_comb begin
        n_kind = r_dv[DV_STAGES].kind;
        n_disc = r_dv[DV_STAGES].disc;
        n_r1   = rnd1.v;
        n_r2   = rnd1.v;
        n_im   = '0;
        n_sat  = rnd1.sat;
        case (r_dv[DV_STAGES].kind)
            KIND_DEGEN: begin
                n_disc = '0;
                n_r1   = '0;
                n_r2   = '0;
                n_sat  = 1'b0;
            end
            KIND_TWO_REAL: begin
                n_r2  = rnd2.v;
                n_sat = rnd1.sat | rnd2.sat;
            end
            KIND_COMPLEX: begin
                n_im  = rnd3.v;
                n_sat = rnd1.sat | rnd3.sat;
            end
            default: begin
                n_r2 = rnd1.v;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv_v[DV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind <= n_kind;
            r_disc <= n_disc;
            r_r1   <= n_r1;
            r_r2   <= n_r2;
            r_im   <= n_im;
            r_sat  <= n_sat;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.root_kind    = r_kind;
    assign o_out.discriminant = r_disc;
    assign o_out.first_root   = r_r1;
    assign o_out.second_root  = r_r2;
    assign o_out.imag_part    = r_im;
    assign o_out.saturated    = r_sat;

endmodule

### hw/rtl/quadratic_root_solver.sv
// top level of the quadratic root solver: front end, queue and root pipeline
// path: an accepted transaction passes the front end, the queue, the square root
//   stages, the divider stages and the result register, in that order
// throughput: one transaction per cycle while o_out.ready; the root pipeline
//   has a stage per sqrt bit (32) and quotient bit (44), all moving together
// reset: i_rst_n synchronous active low clears all valid bits and the queue
module quadratic_root_solver import qrs_pkg::*; #(
    parameter int QUEUE_DEPTH = QRS_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qrs_in_if.sink    i_in,
    qrs_out_if.source o_out
);

    // front end to queue
    t_front_item front_item;
    logic        front_valid;
    logic        front_ready;

    // queue to root pipeline
    t_front_item back_item;
    logic        back_valid;
    logic        back_ready;

    // multiplies, forms the exact discriminant and picks the root kind
    qrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready)
    );

    // decouples the front end from the long root pipeline
    qrs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (front_item),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_data  (back_item),
        .o_valid (back_valid),
        .i_ready (back_ready)
    );

    // square root, three rounded dividers, saturation and result register
    qrs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (back_item),
        .i_item_valid (back_valid),
        .o_item_ready (back_ready),
        .o_out        (o_out)
    );

endmodule
